/* rtl/rsput_pkg.sv */
// Package with the shared constants and the sequencer state type of the range-sum tree.
`default_nettype none

package rsput_pkg;

  // Default number of leaves in the tree.
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;

  // Field widths of the command and result words.
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 11;

  // Element count after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Operation codes carried on the mode port.
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_PATH,
    ST_QRY_CHECK,
    ST_QRY_A,
    ST_QRY_B
  } state_t;

endpackage

`default_nettype wire

/* rtl/rsput_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module rsput_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/range_sum_point_update_tree.sv */
// Top level of the range-sum / point-update tree over signed 64-bit elements.
//
// After reset the block sweeps all 2*MAX_ELEMENTS nodes of its memory to zero (2048 at
// the default), one node a cycle; busy stays high during that sweep. A word is taken
// when start is high and busy is low. A set walks from the leaf to the root, one node
// a cycle, with busy high until the root is written. A query visits at most two nodes
// per tree level through the single read port, with busy high until the walk ends. A
// rejected word does not raise busy at all. Each result appears for exactly one cycle
// with done high, in the cycle after the last step of its word; the receiver cannot
// stall it and must take it then. The element count is written through the cfg
// channel, which is always ready; the user must write it only while the block is
// idle, and the block itself does not enforce this. Values of the elements are kept
// in the leaves of the tree itself.
`default_nettype none

module range_sum_point_update_tree #(
  parameter int unsigned MAX_ELEMENTS = rsput_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rsput_pkg::COUNT_W-1:0]   cfg_data,
  // Command side.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            mode,
  input  wire logic [rsput_pkg::INDEX_W-1:0]   index,
  input  wire logic [rsput_pkg::INDEX_W-1:0]   right_index,
  input  wire logic [rsput_pkg::VALUE_W-1:0]   new_value,
  // Result side.
  output logic                                 done,
  output logic [rsput_pkg::VALUE_W-1:0]        range_total,
  output logic                                 error
);

  localparam int unsigned DEPTH = 2 * MAX_ELEMENTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = (AW + 1 > rsput_pkg::COUNT_W) ? AW + 1 : rsput_pkg::COUNT_W;
  localparam int unsigned VW    = rsput_pkg::VALUE_W;

  localparam logic [EW-1:0] MAX_E      = EW'(MAX_ELEMENTS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROOT_ADDR  = AW'(1);

  rsput_pkg::state_t state, state_next;

  logic [rsput_pkg::COUNT_W-1:0] element_count;
  logic [AW-1:0]                 clr_addr;
  logic [AW-1:0]                 node_p;
  logic [AW:0]                   node_a;
  logic [AW:0]                   node_b;
  logic [VW-1:0]                 set_value;
  logic [VW-1:0]                 delta;
  logic [VW-1:0]                 acc;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [VW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [VW-1:0] ram_rd_data;

  logic          accept;
  logic          req_err;
  logic          fin;
  logic [EW-1:0] cnt_ext;
  logic [EW-1:0] eff_count;
  logic [EW-1:0] left_ext;
  logic [EW-1:0] right_ext;
  logic [EW-1:0] leaf_left;
  logic [EW-1:0] leaf_right_end;
  logic [AW:0]   b_minus_one;
  logic [AW:0]   a_plus_one;

  assign cfg_ready = 1'b1;
  assign busy      = (state != rsput_pkg::ST_IDLE);
  assign accept    = start && !busy;

  // Range check of the incoming word against the effective element count.
  assign cnt_ext        = EW'(element_count);
  assign eff_count      = (cnt_ext > MAX_E) ? MAX_E : cnt_ext;
  assign left_ext       = EW'(index);
  assign right_ext      = EW'(right_index);
  assign leaf_left      = left_ext + MAX_E;
  assign leaf_right_end = right_ext + MAX_E + EW'(1);
  assign req_err        = (left_ext >= eff_count) ||
                          ((mode == rsput_pkg::MODE_QUERY) &&
                           ((right_ext >= eff_count) || (left_ext > right_ext)));

  assign b_minus_one = node_b - (AW + 1)'(1);
  assign a_plus_one  = node_a + (AW + 1)'(1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      rsput_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = rsput_pkg::ST_IDLE;
      end
      rsput_pkg::ST_IDLE: begin
        if (accept && !req_err) begin
          state_next = (mode == rsput_pkg::MODE_SET) ? rsput_pkg::ST_UPD_LEAF
                                                     : rsput_pkg::ST_QRY_CHECK;
        end
      end
      rsput_pkg::ST_UPD_LEAF: state_next = rsput_pkg::ST_UPD_PATH;
      rsput_pkg::ST_UPD_PATH: begin
        if (node_p == ROOT_ADDR) state_next = rsput_pkg::ST_IDLE;
      end
      rsput_pkg::ST_QRY_CHECK: begin
        if (!(node_a < node_b))  state_next = rsput_pkg::ST_IDLE;
        else if (node_a[0])      state_next = rsput_pkg::ST_QRY_A;
        else if (node_b[0])      state_next = rsput_pkg::ST_QRY_B;
      end
      rsput_pkg::ST_QRY_A: begin
        state_next = node_b[0] ? rsput_pkg::ST_QRY_B : rsput_pkg::ST_QRY_CHECK;
      end
      rsput_pkg::ST_QRY_B: state_next = rsput_pkg::ST_QRY_CHECK;
      default:             state_next = rsput_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and the end-of-word flag.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = node_p;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = node_p >> 1;
    fin         = 1'b0;
    unique case (state)
      rsput_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
      end
      rsput_pkg::ST_IDLE: begin
        // Fetch the old leaf value of a set right away.
        ram_rd_en   = accept && !req_err && (mode == rsput_pkg::MODE_SET);
        ram_rd_addr = leaf_left[AW-1:0];
        fin         = accept && req_err;
      end
      rsput_pkg::ST_UPD_LEAF: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = set_value;
        ram_rd_en   = 1'b1;
      end
      rsput_pkg::ST_UPD_PATH: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data + delta;
        ram_rd_en   = (node_p != ROOT_ADDR);
        fin         = (node_p == ROOT_ADDR);
      end
      rsput_pkg::ST_QRY_CHECK: begin
        if (!(node_a < node_b)) begin
          fin = 1'b1;
        end else if (node_a[0]) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = node_a[AW-1:0];
        end else if (node_b[0]) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = b_minus_one[AW-1:0];
        end
      end
      rsput_pkg::ST_QRY_A: begin
        ram_rd_en   = node_b[0];
        ram_rd_addr = b_minus_one[AW-1:0];
      end
      rsput_pkg::ST_QRY_B: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rsput_pkg::ST_CLEAR;
      clr_addr      <= '0;
      element_count <= rsput_pkg::COUNT_RESET;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == rsput_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cfg_valid && cfg_ready) element_count <= cfg_data;
    end
  end

  // Datapath registers: tree walk pointers, running delta and accumulator.
  always_ff @(posedge clk) begin
    case (state)
      rsput_pkg::ST_IDLE: begin
        node_p    <= leaf_left[AW-1:0];
        node_a    <= leaf_left[AW:0];
        node_b    <= leaf_right_end[AW:0];
        set_value <= new_value;
        acc       <= '0;
      end
      rsput_pkg::ST_UPD_LEAF: begin
        delta  <= set_value - ram_rd_data;
        node_p <= node_p >> 1;
      end
      rsput_pkg::ST_UPD_PATH: begin
        node_p <= node_p >> 1;
      end
      rsput_pkg::ST_QRY_CHECK: begin
        if ((node_a < node_b) && !node_a[0] && !node_b[0]) begin
          node_a <= node_a >> 1;
          node_b <= node_b >> 1;
        end
      end
      rsput_pkg::ST_QRY_A: begin
        acc <= acc + ram_rd_data;
        if (node_b[0]) begin
          node_a <= a_plus_one;
        end else begin
          node_a <= a_plus_one >> 1;
          node_b <= node_b >> 1;
        end
      end
      rsput_pkg::ST_QRY_B: begin
        acc    <= acc + ram_rd_data;
        node_a <= node_a >> 1;
        node_b <= node_b >> 1;
      end
      default: begin
      end
    endcase
  end

  // Result word, valid for one cycle with done.
  always_ff @(posedge clk) begin
    if (fin) begin
      error       <= (state == rsput_pkg::ST_IDLE);
      range_total <= (state == rsput_pkg::ST_QRY_CHECK) ? acc : '0;
    end
  end

  // Node memory of the tree; leaves hold the element values.
  rsput_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the range-sum / point-update tree: directed and random words against a mirror of the element array.
module tb;
  import rsput_pkg::*;

  // One command word and the result it should produce.
  typedef struct {
    logic                 op;
    logic [INDEX_W-1:0]   lo_idx;
    logic [INDEX_W-1:0]   hi_idx;
    logic [VALUE_W-1:0]   value;
  } request_t;

  typedef struct {
    logic [VALUE_W-1:0]   total;
    logic                 err;
  } outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 start;
  logic                 busy;
  logic                 mode;
  logic [INDEX_W-1:0]   index;
  logic [INDEX_W-1:0]   right_index;
  logic [VALUE_W-1:0]   new_value;
  logic                 done;
  logic [VALUE_W-1:0]   range_total;
  logic                 error;

  // Mirror of the element array and of the count register.
  logic [VALUE_W-1:0]   shadow_elems [0:MAX_ELEMENTS_DEF-1];
  logic [COUNT_W-1:0]   active_count;
  outcome_t             pending_outcomes [$];
  int unsigned          mismatch_count;
  int unsigned          idle_pct;

  range_sum_point_update_tree dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .index       (index),
    .right_index (right_index),
    .new_value   (new_value),
    .done        (done),
    .range_total (range_total),
    .error       (error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Effective bound on indices: the count saturates at the tree size.
  function automatic int unsigned index_limit();
    return (active_count > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(active_count);
  endfunction

  // Applies one accepted word to the mirror and returns the result it must produce.
  function automatic outcome_t predict_outcome(request_t r);
    outcome_t      o;
    int unsigned   lim;
    logic [VALUE_W-1:0] acc;
    lim = index_limit();
    o.total = '0;
    o.err = 1'b0;
    if (r.op == MODE_SET) begin
      if (r.lo_idx >= lim) o.err = 1'b1;
      else shadow_elems[r.lo_idx] = r.value;
    end else if (r.lo_idx >= lim || r.hi_idx >= lim || r.lo_idx > r.hi_idx) begin
      o.err = 1'b1;
    end else begin
      // The tree must give the plain wrapped sum of the range.
      acc = '0;
      for (int k = r.lo_idx; k <= r.hi_idx; k++) acc += shadow_elems[k];
      o.total = acc;
    end
    return o;
  endfunction

  // Every result is compared with the oldest expectation.
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result total=%h error=%b with none expected",
                                  range_total, error));
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (range_total !== exp_o.total)
          report_mismatch($sformatf("range_total %h, expected %h", range_total, exp_o.total));
        if (error !== exp_o.err)
          report_mismatch($sformatf("error %b, expected %b", error, exp_o.err));
      end
    end
  end

  // Sends one word and records its expected result. Called and left at a falling edge;
  // unless a random gap is drawn, start stays high so that a following word can go out without a gap.
  task automatic send_word(input request_t r);
    start = 1'b1;
    mode = r.op;
    index = r.lo_idx;
    right_index = r.hi_idx;
    new_value = r.value;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_outcomes.push_back(predict_outcome(r));
    @(negedge clk);
    // Random gap after the word, long enough to land anywhere in the block's walk.
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  function automatic request_t make_word(logic op, int unsigned lo, int unsigned hi,
                                         logic [VALUE_W-1:0] v);
    request_t r;
    r.op = op;
    r.lo_idx = lo[INDEX_W-1:0];
    r.hi_idx = hi[INDEX_W-1:0];
    r.value = v;
    return r;
  endfunction

  // Lets every expected result arrive, then waits out the longest walk.
  task automatic settle_block();
    int unsigned waited;
    start = 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
  endtask

  // Writes the element count; only called while the block is idle.
  task automatic write_element_count(input logic [COUNT_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    active_count = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return '1;
      3: return '0;
      4: return {{56{1'b0}}, 8'($urandom)} - 64'd128;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly in-range words; a few reversed ranges and some fully random noise.
  function automatic request_t random_word();
    request_t      r;
    int unsigned   lim;
    int unsigned   roll;
    int unsigned   a;
    int unsigned   b;
    lim = index_limit();
    r.op = 1'($urandom_range(0, 1));
    r.value = random_value();
    r.lo_idx = INDEX_W'($urandom_range(0, MAX_ELEMENTS_DEF - 1));
    r.hi_idx = INDEX_W'($urandom_range(0, MAX_ELEMENTS_DEF - 1));
    roll = $urandom_range(0, 99);
    if (lim != 0 && roll >= 5) begin
      a = $urandom_range(0, lim - 1);
      if (roll < 35) begin
        b = a + $urandom_range(0, 3);
        if (b >= lim) b = lim - 1;
      end else begin
        b = $urandom_range(0, lim - 1);
      end
      if (roll < 10) begin
        // Reversed range when the two ends differ.
        r.lo_idx = INDEX_W'((a > b) ? a : b);
        r.hi_idx = INDEX_W'((a > b) ? b : a);
      end else begin
        r.lo_idx = INDEX_W'((a < b) ? a : b);
        r.hi_idx = INDEX_W'((a < b) ? b : a);
      end
    end
    return r;
  endfunction

  // Field extremes, wrapping sums, single-element and reversed ranges.
  task automatic test_field_extremes();
    idle_pct = 0;
    send_word(make_word(MODE_SET, 0, 1023, 64'h7FFF_FFFF_FFFF_FFFF));
    send_word(make_word(MODE_SET, 1023, 0, 64'h8000_0000_0000_0000));
    send_word(make_word(MODE_SET, 512, 1023, '1));
    send_word(make_word(MODE_SET, 1, 0, 64'hAAAA_AAAA_AAAA_AAAA));
    send_word(make_word(MODE_SET, 2, 0, 64'h5555_5555_5555_5555));
    send_word(make_word(MODE_QUERY, 0, 1023, '1));
    send_word(make_word(MODE_QUERY, 0, 0, '0));
    send_word(make_word(MODE_QUERY, 1023, 1023, '0));
    send_word(make_word(MODE_QUERY, 0, 2, '0));
    send_word(make_word(MODE_QUERY, 1023, 0, '0));
    // Writing the value already stored leaves every sum unchanged.
    send_word(make_word(MODE_SET, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    send_word(make_word(MODE_QUERY, 0, 1, '0));
    settle_block();
  endtask

  // Zero count, saturated count, a single element, and values kept across changes.
  task automatic test_count_edges();
    idle_pct = 0;
    write_element_count(11'd0);
    send_word(make_word(MODE_SET, 3, 0, 64'd99));
    send_word(make_word(MODE_QUERY, 0, 0, '0));
    settle_block();
    write_element_count(11'd2047);
    send_word(make_word(MODE_QUERY, 1023, 1023, '0));
    send_word(make_word(MODE_SET, 1023, 0, 64'd5));
    settle_block();
    write_element_count(11'd1);
    send_word(make_word(MODE_QUERY, 0, 0, '0));
    send_word(make_word(MODE_SET, 1, 0, 64'd7));
    send_word(make_word(MODE_QUERY, 0, 1, '0));
    settle_block();
    write_element_count(COUNT_RESET);
    send_word(make_word(MODE_QUERY, 0, 1023, '0));
    settle_block();
  endtask

  // Random words under one count setting and one idling rate.
  task automatic test_random_traffic(input int unsigned n_words, input int unsigned gap_pct,
                                     input logic [COUNT_W-1:0] count_setting);
    write_element_count(count_setting);
    idle_pct = gap_pct;
    repeat (n_words) send_word(random_word());
    settle_block();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    mode = MODE_SET;
    index = '0;
    right_index = '0;
    new_value = '0;
    mismatch_count = 0;
    idle_pct = 0;
    active_count = COUNT_RESET;
    for (int k = 0; k < MAX_ELEMENTS_DEF; k++) shadow_elems[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The node memory is swept clear before the first word is taken.
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);

    test_field_extremes();
    test_count_edges();
    test_random_traffic(300, 0, COUNT_RESET);
    test_random_traffic(300, 49, 11'd37);
    test_random_traffic(300, 0, 11'd2047);
    test_random_traffic(300, 10, 11'($urandom_range(2, 1024)));

    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_outcomes.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
